@@ hdl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    // broadcast to every cell for one word
    typedef struct packed
    {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

    // what a cell shows its neighbors
    typedef struct packed
    {
        logic                     greater;
        logic signed [DATA_W-1:0] data;
    } cell_link_t;

endpackage

@@ hdl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds one entry, compares it with the
// incoming word and takes from a neighbor or the new word on update.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                     clk,
    input  logic                     occupied,
    input  cell_ctrl_t               ctrl,
    input  cell_link_t               left,
    input  logic signed [DATA_W-1:0] right,
    output cell_link_t               link
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     greater;

    // an empty slot ranks below everything
    assign greater = !occupied || (ctrl.value > data_reg);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins && greater)
        begin
            data_next = left.greater ? left.data : ctrl.value;
        end
        else if (ctrl.rem)
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign link.greater = greater;
    assign link.data    = data_reg;

endmodule

@@ hdl/sorted_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Max priority queue kept as a sorted row of cells, largest at the front.
//
//   channel   | handshake        | fields
//   ----------+------------------+-------------------------------
//   command   | start / busy     | cmd, value
//   result    | done (strobe)    | out_value, status, occupancy
//
// One word per cycle: every cell compares and shifts in parallel in the
// cycle the word is accepted, and the result shows on done in the cycle after.
// busy stays low; the receiver cannot stall, so results are never held.
// rst_n clears the entry count; entry data needs no reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       cmd,
    input  logic signed [DATA_W-1:0]   value,
    output logic                       done,
    output logic signed [DATA_W-1:0]   out_value,
    output logic [STATUS_W-1:0]        status,
    output logic [OCC_W-1:0]           occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      done_reg;
    logic signed [DATA_W-1:0]  out_value_reg;
    logic signed [DATA_W-1:0]  out_value_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;

    logic                      full;
    logic                      empty;
    logic                      accept;
    cell_ctrl_t                ctrl;
    logic [DEPTH-1:0]          occupied;
    cell_link_t                links [DEPTH];
    cell_link_t                lefts [DEPTH];
    logic signed [DATA_W-1:0]  rights [DEPTH];
    logic [CNT_W+OCC_W-1:0]    count_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    assign ctrl.ins   = accept && (cmd == CMD_INSERT) && !full;
    assign ctrl.rem   = accept && (cmd == CMD_REMOVE) && !empty;
    assign ctrl.value = value;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign occupied[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                assign lefts[gi] = '{greater: 1'b0, data: '0};
            end
            else
            begin : g_mid
                assign lefts[gi] = links[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign rights[gi] = '0;
            end
            else
            begin : g_inner
                assign rights[gi] = links[gi+1].data;
            end

            spq_cell u_cell
            (
                .clk      (clk),
                .occupied (occupied[gi]),
                .ctrl     (ctrl),
                .left     (lefts[gi]),
                .right    (rights[gi]),
                .link     (links[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        out_value_next = '0;
        status_next    = STATUS_OK;
        if (accept)
        begin
            if (cmd == CMD_INSERT)
            begin
                if (full)
                begin
                    status_next = STATUS_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = STATUS_UNDERFLOW;
                end
                else
                begin
                    out_value_next = links[0].data;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
    end

    assign count_ext = {{OCC_W{1'b0}}, count_reg};
    assign done      = done_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign occupancy = count_ext[OCC_W-1:0];

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted word gave no result");

    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_REMOVE && empty) |=>
            (status == STATUS_UNDERFLOW && out_value == '0 && empty))
        else $error("empty remove not flagged as underflow");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_OVERFLOW) |-> full)
        else $error("overflow reported while not full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");
`endif

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_priority_queue_core. A short table of
// hand-picked words walks the corner cases: empty remove, full insert,
// extremes and ties. Random words follow, with the insert share swinging so
// the queue drains and fills repeatedly. A shadow sorted list predicts each
// result not pinned by a table row; results are checked in order against it.
// ----------------------------------------------------------------------------
module testbench
    import spq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH      = DEPTH_DEFAULT;
    localparam int RANDOM_WORDS = 1300;
    localparam int QUIET_TAIL  = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int ROWS        = 21;

    typedef struct
    {
        logic signed [DATA_W-1:0] out_value;
        status_t                  status;
        logic [OCC_W-1:0]         occupancy;
    } queue_result_t;

    typedef struct
    {
        cmd_t                     op;
        logic signed [DATA_W-1:0] arg;
        int                       reps;
        bit                       pinned;
        logic signed [DATA_W-1:0] pin_out;
        status_t                  pin_status;
        logic [OCC_W-1:0]         pin_occ;
    } stimulus_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     cmd;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic signed [DATA_W-1:0] out_value;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;

    logic                     word_pinned;
    logic signed [DATA_W-1:0] word_pin_out;
    status_t                  word_pin_status;
    logic [OCC_W-1:0]         word_pin_occ;

    logic signed [DATA_W-1:0] shadow_list[QDEPTH];
    int                       shadow_count = 0;
    queue_result_t            pending_results[$];
    int                       mismatches = 0;
    int                       idle_cycles = 0;

    stimulus_row_t directed_rows[ROWS] = '{
        '{CMD_REMOVE, 32'sd0,          1,  1'b1, 32'sd0,          STATUS_UNDERFLOW, 5'd0},
        '{CMD_INSERT, 32'sh7fffffff,   1,  1'b1, 32'sd0,          STATUS_OK,        5'd1},
        '{CMD_INSERT, 32'sh80000000,   1,  1'b1, 32'sd0,          STATUS_OK,        5'd2},
        '{CMD_INSERT, 32'shffffffff,   1,  1'b0, 32'sd0,          STATUS_OK,        5'd0},
        '{CMD_INSERT, 32'sd0,          1,  1'b0, 32'sd0,          STATUS_OK,        5'd0},
        '{CMD_INSERT, 32'sd1,          1,  1'b0, 32'sd0,          STATUS_OK,        5'd0},
        '{CMD_INSERT, 32'sd0,          1,  1'b0, 32'sd0,          STATUS_OK,        5'd0},
        '{CMD_INSERT, 32'sh7fffffff,   1,  1'b0, 32'sd0,          STATUS_OK,        5'd0},
        '{CMD_REMOVE, 32'sd0,          1,  1'b1, 32'sh7fffffff,   STATUS_OK,        5'd6},
        '{CMD_INSERT, 32'sha5a5a5a5,   10, 1'b0, 32'sd0,          STATUS_OK,        5'd0},
        '{CMD_INSERT, 32'sh12345678,   1,  1'b1, 32'sd0,          STATUS_OVERFLOW,  5'd16},
        '{CMD_INSERT, 32'sh80000000,   1,  1'b1, 32'sd0,          STATUS_OVERFLOW,  5'd16},
        '{CMD_REMOVE, 32'sd0,          1,  1'b1, 32'sh7fffffff,   STATUS_OK,        5'd15},
        '{CMD_REMOVE, 32'sd0,          14, 1'b0, 32'sd0,          STATUS_OK,        5'd0},
        '{CMD_REMOVE, 32'sd0,          1,  1'b1, 32'sh80000000,   STATUS_OK,        5'd0},
        '{CMD_REMOVE, 32'sd0,          1,  1'b1, 32'sd0,          STATUS_UNDERFLOW, 5'd0},
        '{CMD_REMOVE, 32'shffffffff,   1,  1'b1, 32'sd0,          STATUS_UNDERFLOW, 5'd0},
        '{CMD_INSERT, 32'sh55555555,   1,  1'b0, 32'sd0,          STATUS_OK,        5'd0},
        '{CMD_INSERT, 32'shaaaaaaaa,   1,  1'b0, 32'sd0,          STATUS_OK,        5'd0},
        '{CMD_REMOVE, 32'sd0,          1,  1'b1, 32'sh55555555,   STATUS_OK,        5'd1},
        '{CMD_REMOVE, 32'sh7fffffff,   1,  1'b1, 32'shaaaaaaaa,   STATUS_OK,        5'd0}
    };

    sorted_priority_queue_core #(.DEPTH(QDEPTH)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .value     (value),
        .done      (done),
        .out_value (out_value),
        .status    (status),
        .occupancy (occupancy)
    );

    always #6 clk = ~clk;

    task automatic apply_to_shadow(input cmd_t op, input logic signed [DATA_W-1:0] arg,
                                   output queue_result_t res);
        int slot;
        res.out_value = '0;
        res.status    = STATUS_OK;
        if (op == CMD_INSERT)
        begin
            if (shadow_count >= QDEPTH)
            begin
                res.status = STATUS_OVERFLOW;
            end
            else
            begin
                slot = shadow_count;
                for (int i = shadow_count - 1; i >= 0; i--)
                begin
                    if (arg > shadow_list[i])
                    begin
                        shadow_list[i + 1] = shadow_list[i];
                        slot = i;
                    end
                end
                shadow_list[slot] = arg;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                res.status = STATUS_UNDERFLOW;
            end
            else
            begin
                res.out_value = shadow_list[0];
                for (int i = 1; i < shadow_count; i++)
                    shadow_list[i - 1] = shadow_list[i];
                shadow_count--;
            end
        end
        res.occupancy = shadow_count[OCC_W-1:0];
    endtask

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // accept words, check results
    always @(posedge clk)
    begin
        queue_result_t res;
        queue_result_t want;
        if (rst_n && start && !busy)
        begin
            apply_to_shadow(cmd_t'(cmd), value, res);
            if (word_pinned)
            begin
                res.out_value = word_pin_out;
                res.status    = word_pin_status;
                res.occupancy = word_pin_occ;
            end
            pending_results.push_back(res);
        end
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch("result word with none expected");
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_value !== want.out_value)
                    flag_mismatch($sformatf("out_value %0d, expected %0d",
                                            out_value, want.out_value));
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            status, want.status));
                if (occupancy !== want.occupancy)
                    flag_mismatch($sformatf("occupancy %0d, expected %0d",
                                            occupancy, want.occupancy));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || (rst_n && done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(input cmd_t op, input logic signed [DATA_W-1:0] arg,
                             input int gap, input bit pinned,
                             input logic signed [DATA_W-1:0] p_out,
                             input status_t p_status, input logic [OCC_W-1:0] p_occ);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start           <= 1'b1;
        cmd             <= op;
        value           <= arg;
        word_pinned     <= pinned;
        word_pin_out    <= p_out;
        word_pin_status <= p_status;
        word_pin_occ    <= p_occ;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic int pick_gap(input bit idling);
        if (!idling || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 7);
    endfunction

    initial
    begin
        cmd_t                     op;
        logic signed [DATA_W-1:0] arg;
        int                       insert_pct;
        bit                       idling;

        rst_n           = 1'b0;
        start           = 1'b0;
        cmd             = CMD_INSERT;
        value           = '0;
        word_pinned     = 1'b0;
        word_pin_out    = '0;
        word_pin_status = STATUS_OK;
        word_pin_occ    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idling = 1'b1;
        foreach (directed_rows[r])
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_word(directed_rows[r].op, directed_rows[r].arg, pick_gap(idling),
                          directed_rows[r].pinned, directed_rows[r].pin_out,
                          directed_rows[r].pin_status, directed_rows[r].pin_occ);
        end

        insert_pct = 50;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 50;
                    default: insert_pct = 15;
                endcase
                idling = ($urandom_range(0, 2) != 0) && (n < RANDOM_WORDS - QUIET_TAIL);
            end
            op = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            case ($urandom_range(0, 3))
                0: arg = int'($urandom_range(0, 8)) - 4;
                1:
                begin
                    case ($urandom_range(0, 3))
                        0: arg = 32'sh7fffffff;
                        1: arg = 32'sh80000000;
                        2: arg = 32'sd0;
                        default: arg = -32'sd1;
                    endcase
                end
                default: arg = $urandom();
            endcase
            send_word(op, arg, pick_gap(idling), 1'b0, '0, STATUS_OK, '0);
        end
        @(negedge clk);
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_core.sv
bench/testbench.sv
